[rtl/motor_speed_pid_regulator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the motor speed regulator
// Concurrent property wrappers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_PID_REGULATOR_ASSERT_SVH
`define MOTOR_SPEED_PID_REGULATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MSPR_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mspr: same-cycle property failed");
// next-cycle implication
`define MSPR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mspr: next-cycle property failed");
`else
`define MSPR_ASSERT_IMP(name, clk, rst, ante, cons)
`define MSPR_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

[rtl/mspr_pkg.sv]
// ----------------------------------------------------------------------------
// Motor speed regulator package
// Constants, register indexes, event kinds and sequencer states.
// ----------------------------------------------------------------------------
package mspr_pkg;

   localparam longint MEASURE_NUMERATOR = 1000000;
   localparam logic [15:0] PID_DIVISOR = 16'd100;
   localparam logic [15:0] SPEED_LOW_LIMIT = 16'd20;
   localparam logic [9:0] OVERFLOW_LIMIT = 10'd500;

   localparam logic [15:0] DRIVE_START = 16'd750;
   localparam logic [16:0] TARGET_FLOOR = 17'(SPEED_LOW_LIMIT) + 17'd10;
   localparam logic [9:0] TALLY_MAX = 10'd1023;

   // register reset values
   localparam logic [15:0] TARGET_RESET = 16'd650;
   localparam logic [15:0] GAIN_P_RESET = 16'd50;
   localparam logic [15:0] GAIN_I_RESET = 16'd10;
   localparam logic [15:0] GAIN_D_RESET = 16'd20;
   localparam logic [15:0] SPEED_HIGH_RESET = 16'd1000;
   localparam logic [15:0] DRIVE_LOW_RESET = 16'd450;
   localparam logic [15:0] DRIVE_HIGH_RESET = 16'd1050;

   // datapath widths
   localparam int NUM_W = $clog2(MEASURE_NUMERATOR + 1);
   localparam int SUM_W = 36;
   localparam int DIV_W = (NUM_W > SUM_W) ? NUM_W : SUM_W;
   localparam int DEN_W = 16;
   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam int ACC_W = DIV_W + 2;

   typedef enum logic [1:0] {
      KIND_REVOLUTION = 2'd0,
      KIND_CONTROL    = 2'd1,
      KIND_OVERFLOW   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CSR_TARGET_SPEED = 3'd0,
      CSR_GAIN_P       = 3'd1,
      CSR_GAIN_I       = 3'd2,
      CSR_GAIN_D       = 3'd3,
      CSR_REGULATE_ON  = 3'd4,
      CSR_SPEED_HIGH   = 3'd5,
      CSR_DRIVE_LOW    = 3'd6,
      CSR_DRIVE_HIGH   = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERROR,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_MUL_SUM,
      ST_DIV_LOAD,
      ST_DIV,
      ST_SPEED,
      ST_DRIVE,
      ST_RESULT
   } state_type;

endpackage

[rtl/mspr_ifs.sv]
// ----------------------------------------------------------------------------
// Motor speed regulator channels
// Event request, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface mspr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] period_count;

   modport source (output valid, output kind, output period_count, input ready);
   modport sink (input valid, input kind, input period_count, output ready);
endinterface

interface mspr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] measured_speed;
   logic [15:0] drive_value;
   logic        drive_updated;
   logic        regulating;
   logic        period_was_zero;

   modport source (output valid, output measured_speed, output drive_value,
                   output drive_updated, output regulating, output period_was_zero,
                   input ready);
   modport sink (input valid, input measured_speed, input drive_value,
                 input drive_updated, input regulating, input period_was_zero,
                 output ready);
endinterface

interface mspr_csr_if;
   logic                        valid;
   logic                        ready;
   mspr_pkg::csr_index_type     index;
   logic [15:0]                 data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/motor_speed_pid_regulator.sv]
// ----------------------------------------------------------------------------
// Motor speed PID regulator
// Speed measurement from revolution period, incremental PID on control ticks,
// overflow timeout. One shared multiplier and one shared restoring divider.
// ----------------------------------------------------------------------------
// Revolution event: 36 divider steps, then the speed window check; a zero period skips both.
// Control tick while regulating: the result follows the steps error, three multiplies
//    on one multiplier, sum, divider and drive clamp.
// Other events go straight to ST_RESULT, which loads the result. req.ready returns with
//    the result load, so no new event is taken before then; a stalled result holds it.
// Synchronous reset restores register defaults, drive 750, and clears the regulator state and result valid.
`include "motor_speed_pid_regulator_assert.svh"

module motor_speed_pid_regulator (
   input logic         clock,
   input logic         reset,
   mspr_req_if.sink    req,
   mspr_rsp_if.source  rsp,
   mspr_csr_if.sink    csr
);

   mspr_pkg::state_type state_ff, state_in;

   // configuration
   logic [15:0]        target_ff, target_in;
   logic signed [15:0] gain_p_ff, gain_p_in;
   logic signed [15:0] gain_i_ff, gain_i_in;
   logic signed [15:0] gain_d_ff, gain_d_in;
   logic               regulate_on_ff, regulate_on_in;
   logic [15:0]        speed_high_ff, speed_high_in;
   logic [15:0]        drive_low_ff, drive_low_in;
   logic [15:0]        drive_high_ff, drive_high_in;

   // regulator state
   logic [15:0]        speed_ff, speed_in;
   logic signed [15:0] err1_ff, err1_in;
   logic signed [15:0] err2_ff, err2_in;
   logic [15:0]        acc_ff, acc_in;
   logic [9:0]         tally_ff, tally_in;
   logic               stop_ff, stop_in;

   // working registers
   logic signed [15:0]        e_ff, e_in;
   logic signed [17:0]        s_ff, s_in;
   logic signed [16:0]        d_ff, d_in;
   logic signed [33:0]        prod_ff, prod_in;
   logic signed [mspr_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                      neg_ff, neg_in;
   logic [mspr_pkg::DIV_W-1:0] div_quo_ff, div_quo_in;
   logic [mspr_pkg::DEN_W-1:0] div_rem_ff, div_rem_in;
   logic [mspr_pkg::DEN_W-1:0] div_den_ff, div_den_in;
   logic [mspr_pkg::CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                      div_pid_ff, div_pid_in;
   logic                      updated_ff, updated_in;
   logic                      zero_ff, zero_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_speed_ff, rsp_speed_in;
   logic [15:0] rsp_drive_ff, rsp_drive_in;
   logic        rsp_updated_ff, rsp_updated_in;
   logic        rsp_regulating_ff, rsp_regulating_in;
   logic        rsp_zero_ff, rsp_zero_in;

   // combinational helpers
   logic [15:0]        tgt_eff;
   logic signed [16:0] err_diff;
   logic signed [15:0] err_sat;
   logic signed [34:0] prod_wide;
   logic signed [34:0] prod_half;
   logic signed [mspr_pkg::SUM_W-1:0] sum_neg;
   logic [mspr_pkg::SUM_W-1:0] sum_mag;
   logic [mspr_pkg::DEN_W:0]   rem_sh;
   logic                      rem_ge;
   logic [mspr_pkg::DEN_W-1:0] rem_next;
   logic [15:0]               speed_q;
   logic signed [mspr_pkg::ACC_W-1:0] acc_base, acc_delta, acc_sum;
   logic signed [mspr_pkg::ACC_W-1:0] acc_hi_lim, acc_lo_lim, acc_hi, acc_lo;
   logic                      regulating;

   assign regulating = regulate_on_ff && !stop_ff;

   // effective target, error and its saturation
   always_comb begin
      if (17'(target_ff) <= mspr_pkg::TARGET_FLOOR) begin
         tgt_eff = '0;
      end else if (target_ff >= speed_high_ff) begin
         tgt_eff = speed_high_ff;
      end else begin
         tgt_eff = target_ff;
      end
      err_diff = $signed({1'b0, tgt_eff}) - $signed({1'b0, speed_ff});
      if (err_diff > 17'sd32767) begin
         err_sat = 16'sh7fff;
      end else if (err_diff < -17'sd32768) begin
         err_sat = 16'sh8000;
      end else begin
         err_sat = err_diff[15:0];
      end
   end

   // derivative product halved, truncating toward zero
   assign prod_wide = 35'(prod_ff) + $signed({34'd0, prod_ff[33]});
   assign prod_half = prod_wide >>> 1;

   assign sum_neg = -sum_ff;
   assign sum_mag = sum_ff[mspr_pkg::SUM_W-1] ? sum_neg : sum_ff;

   // one restoring divider step
   assign rem_sh = {div_rem_ff, div_quo_ff[mspr_pkg::DIV_W-1]};
   assign rem_ge = rem_sh >= {1'b0, div_den_ff};
   always_comb begin
      if (rem_ge) begin
         rem_next = mspr_pkg::DEN_W'(rem_sh - {1'b0, div_den_ff});
      end else begin
         rem_next = rem_sh[mspr_pkg::DEN_W-1:0];
      end
   end

   // speed window check on the quotient
   always_comb begin
      if (div_quo_ff <= mspr_pkg::DIV_W'(mspr_pkg::SPEED_LOW_LIMIT) ||
          div_quo_ff > mspr_pkg::DIV_W'(speed_high_ff)) begin
         speed_q = '0;
      end else begin
         speed_q = div_quo_ff[15:0];
      end
   end

   // accumulator update and clamp; high first, then low
   always_comb begin
      acc_base   = $signed(mspr_pkg::ACC_W'(acc_ff));
      acc_delta  = $signed(mspr_pkg::ACC_W'(div_quo_ff));
      acc_sum    = neg_ff ? (acc_base - acc_delta) : (acc_base + acc_delta);
      acc_hi_lim = $signed(mspr_pkg::ACC_W'(drive_high_ff));
      acc_lo_lim = $signed(mspr_pkg::ACC_W'(drive_low_ff));
      acc_hi     = (acc_sum >= acc_hi_lim) ? acc_hi_lim : acc_sum;
      acc_lo     = (acc_hi <= acc_lo_lim) ? acc_lo_lim : acc_hi;
   end

   // sequencer
   always_comb begin
      state_in          = state_ff;
      target_in         = target_ff;
      gain_p_in         = gain_p_ff;
      gain_i_in         = gain_i_ff;
      gain_d_in         = gain_d_ff;
      regulate_on_in    = regulate_on_ff;
      speed_high_in     = speed_high_ff;
      drive_low_in      = drive_low_ff;
      drive_high_in     = drive_high_ff;
      speed_in          = speed_ff;
      err1_in           = err1_ff;
      err2_in           = err2_ff;
      acc_in            = acc_ff;
      tally_in          = tally_ff;
      stop_in           = stop_ff;
      e_in              = e_ff;
      s_in              = s_ff;
      d_in              = d_ff;
      prod_in           = prod_ff;
      sum_in            = sum_ff;
      neg_in            = neg_ff;
      div_quo_in        = div_quo_ff;
      div_rem_in        = div_rem_ff;
      div_den_in        = div_den_ff;
      div_cnt_in        = div_cnt_ff;
      div_pid_in        = div_pid_ff;
      updated_in        = updated_ff;
      zero_in           = zero_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_speed_in      = rsp_speed_ff;
      rsp_drive_in      = rsp_drive_ff;
      rsp_updated_in    = rsp_updated_ff;
      rsp_regulating_in = rsp_regulating_ff;
      rsp_zero_in       = rsp_zero_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mspr_pkg::ST_IDLE: begin
            if (req.valid) begin
               updated_in = 1'b0;
               zero_in    = 1'b0;
               state_in   = mspr_pkg::ST_RESULT;
               case (req.kind)
                  mspr_pkg::KIND_REVOLUTION: begin
                     if (req.period_count == '0) begin
                        speed_in = '0;
                        zero_in  = 1'b1;
                     end else begin
                        div_quo_in = mspr_pkg::DIV_W'(mspr_pkg::MEASURE_NUMERATOR);
                        div_rem_in = '0;
                        div_den_in = req.period_count;
                        div_cnt_in = mspr_pkg::CNT_W'(mspr_pkg::DIV_W);
                        div_pid_in = 1'b0;
                        state_in   = mspr_pkg::ST_DIV;
                     end
                  end
                  mspr_pkg::KIND_CONTROL: begin
                     if (regulating) begin
                        updated_in = 1'b1;
                        state_in   = mspr_pkg::ST_ERROR;
                     end
                  end
                  mspr_pkg::KIND_OVERFLOW: begin
                     if (tally_ff < mspr_pkg::TALLY_MAX) begin
                        tally_in = tally_ff + 10'd1;
                     end
                     if (tally_in >= mspr_pkg::OVERFLOW_LIMIT) begin
                        stop_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mspr_pkg::ST_ERROR: begin
            e_in     = err_sat;
            s_in     = 18'(err_sat) + 18'(err1_ff) + 18'(err2_ff);
            d_in     = 17'(err_sat) - 17'(err1_ff);
            state_in = mspr_pkg::ST_MUL_P;
         end
         mspr_pkg::ST_MUL_P: begin
            prod_in  = gain_p_ff * 18'(e_ff);
            sum_in   = '0;
            state_in = mspr_pkg::ST_MUL_I;
         end
         mspr_pkg::ST_MUL_I: begin
            sum_in   = sum_ff + mspr_pkg::SUM_W'(prod_ff);
            prod_in  = gain_i_ff * s_ff;
            state_in = mspr_pkg::ST_MUL_D;
         end
         mspr_pkg::ST_MUL_D: begin
            sum_in   = sum_ff + mspr_pkg::SUM_W'(prod_ff);
            prod_in  = gain_d_ff * 18'(d_ff);
            state_in = mspr_pkg::ST_MUL_SUM;
         end
         mspr_pkg::ST_MUL_SUM: begin
            sum_in   = sum_ff + mspr_pkg::SUM_W'(prod_half);
            state_in = mspr_pkg::ST_DIV_LOAD;
         end
         mspr_pkg::ST_DIV_LOAD: begin
            // divide the magnitude, restore the sign when applying
            neg_in     = sum_ff[mspr_pkg::SUM_W-1];
            div_quo_in = mspr_pkg::DIV_W'(sum_mag);
            div_rem_in = '0;
            div_den_in = mspr_pkg::PID_DIVISOR;
            div_cnt_in = mspr_pkg::CNT_W'(mspr_pkg::DIV_W);
            div_pid_in = 1'b1;
            state_in   = mspr_pkg::ST_DIV;
         end
         mspr_pkg::ST_DIV: begin
            div_rem_in = rem_next;
            div_quo_in = {div_quo_ff[mspr_pkg::DIV_W-2:0], rem_ge};
            div_cnt_in = div_cnt_ff - mspr_pkg::CNT_W'(1);
            if (div_cnt_ff == mspr_pkg::CNT_W'(1)) begin
               state_in = div_pid_ff ? mspr_pkg::ST_DRIVE : mspr_pkg::ST_SPEED;
            end
         end
         mspr_pkg::ST_SPEED: begin
            speed_in = speed_q;
            state_in = mspr_pkg::ST_RESULT;
         end
         mspr_pkg::ST_DRIVE: begin
            acc_in   = acc_lo[15:0];
            err2_in  = err1_ff;
            err1_in  = e_ff;
            state_in = mspr_pkg::ST_RESULT;
         end
         mspr_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in      = 1'b1;
               rsp_speed_in      = speed_ff;
               rsp_drive_in      = acc_ff;
               rsp_updated_in    = updated_ff;
               rsp_regulating_in = regulating;
               rsp_zero_in       = zero_ff;
               state_in          = mspr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mspr_pkg::ST_IDLE;
         end
      endcase

      if (csr.valid) begin
         unique case (csr.index)
            mspr_pkg::CSR_TARGET_SPEED: target_in      = csr.data;
            mspr_pkg::CSR_GAIN_P:       gain_p_in      = csr.data;
            mspr_pkg::CSR_GAIN_I:       gain_i_in      = csr.data;
            mspr_pkg::CSR_GAIN_D:       gain_d_in      = csr.data;
            mspr_pkg::CSR_REGULATE_ON:  regulate_on_in = csr.data[0];
            mspr_pkg::CSR_SPEED_HIGH:   speed_high_in  = csr.data;
            mspr_pkg::CSR_DRIVE_LOW:    drive_low_in   = csr.data;
            mspr_pkg::CSR_DRIVE_HIGH:   drive_high_in  = csr.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mspr_pkg::ST_IDLE;
         target_ff      <= mspr_pkg::TARGET_RESET;
         gain_p_ff      <= mspr_pkg::GAIN_P_RESET;
         gain_i_ff      <= mspr_pkg::GAIN_I_RESET;
         gain_d_ff      <= mspr_pkg::GAIN_D_RESET;
         regulate_on_ff <= 1'b0;
         speed_high_ff  <= mspr_pkg::SPEED_HIGH_RESET;
         drive_low_ff   <= mspr_pkg::DRIVE_LOW_RESET;
         drive_high_ff  <= mspr_pkg::DRIVE_HIGH_RESET;
         speed_ff       <= '0;
         err1_ff        <= '0;
         err2_ff        <= '0;
         acc_ff         <= mspr_pkg::DRIVE_START;
         tally_ff       <= '0;
         stop_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         target_ff      <= target_in;
         gain_p_ff      <= gain_p_in;
         gain_i_ff      <= gain_i_in;
         gain_d_ff      <= gain_d_in;
         regulate_on_ff <= regulate_on_in;
         speed_high_ff  <= speed_high_in;
         drive_low_ff   <= drive_low_in;
         drive_high_ff  <= drive_high_in;
         speed_ff       <= speed_in;
         err1_ff        <= err1_in;
         err2_ff        <= err2_in;
         acc_ff         <= acc_in;
         tally_ff       <= tally_in;
         stop_ff        <= stop_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff              <= e_in;
      s_ff              <= s_in;
      d_ff              <= d_in;
      prod_ff           <= prod_in;
      sum_ff            <= sum_in;
      neg_ff            <= neg_in;
      div_quo_ff        <= div_quo_in;
      div_rem_ff        <= div_rem_in;
      div_den_ff        <= div_den_in;
      div_cnt_ff        <= div_cnt_in;
      div_pid_ff        <= div_pid_in;
      updated_ff        <= updated_in;
      zero_ff           <= zero_in;
      rsp_speed_ff      <= rsp_speed_in;
      rsp_drive_ff      <= rsp_drive_in;
      rsp_updated_ff    <= rsp_updated_in;
      rsp_regulating_ff <= rsp_regulating_in;
      rsp_zero_ff       <= rsp_zero_in;
   end

   assign req.ready           = (state_ff == mspr_pkg::ST_IDLE);
   assign csr.ready           = 1'b1;
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.measured_speed  = rsp_speed_ff;
   assign rsp.drive_value     = rsp_drive_ff;
   assign rsp.drive_updated   = rsp_updated_ff;
   assign rsp.regulating      = rsp_regulating_ff;
   assign rsp.period_was_zero = rsp_zero_ff;

   `MSPR_ASSERT_NEXT(a_transfer_starts_work, clock, reset, req.valid && req.ready,
      state_ff != mspr_pkg::ST_IDLE)
   `MSPR_ASSERT_IMP(a_stop_needs_tally, clock, reset, stop_ff,
      tally_ff >= mspr_pkg::OVERFLOW_LIMIT)
   `MSPR_ASSERT_IMP(a_update_while_regulating, clock, reset,
      rsp.valid && rsp.drive_updated, rsp.regulating)
   `MSPR_ASSERT_IMP(a_zero_period_speed, clock, reset, rsp.valid && rsp.period_was_zero,
      rsp.measured_speed == 16'd0 && !rsp.drive_updated)

endmodule
